[sv/acs_pkg.sv]
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types and constants for the Annex B config header splitter.
// ----------------------------------------------------------------------------
package acs_pkg;

  // Frame byte counter width; payload offset and lengths on the result are 24 bits.
  localparam int unsigned FRAME_LEN_BITS = 24;
  localparam int unsigned POS_W          = FRAME_LEN_BITS;
  localparam int unsigned LEN_W          = 24;

  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 80;

  // Codec codes of the configuration register.
  localparam logic [1:0] CODEC_H264 = 2'd0;
  localparam logic [1:0] CODEC_HEVC = 2'd1;
  localparam logic [1:0] CODEC_AV1  = 2'd2;

  // NAL unit types.
  localparam logic [5:0] NAL_AUD_H264 = 6'd9;
  localparam logic [5:0] NAL_AUD_HEVC = 6'd35;
  localparam logic [5:0] NAL_SPS_H264 = 6'd7;
  localparam logic [5:0] NAL_VPS_HEVC = 6'd32;

  // Delimiter bytes, NAL header included, that follow its start code.
  localparam logic [2:0] AUD_BODY_H264 = 3'd2;
  localparam logic [2:0] AUD_BODY_HEVC = 3'd3;

  // Start codes counted before the config span ends.
  localparam logic [2:0] CODES_H264 = 3'd3;
  localparam logic [2:0] CODES_HEVC = 3'd4;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_LEAD_TYPE,
    PH_AUD_PREFIX,
    PH_AUD_TYPE,
    PH_SCAN,
    PH_IDLE,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    PFX_WAIT,
    PFX_FOUND,
    PFX_BAD
  } pfx_e;

  // What the byte stage hands to the result stage at the end of a frame.
  typedef struct packed {
    logic [POS_W-1:0] len;
    logic             ovf;
    logic [2:0]       skip;
    logic [2:0]       lead;
    logic [LEN_W-1:0] hdr_end;
    logic             done;
    logic [1:0]       codec;
  } frame_sum_t;

endpackage

[sv/annexb_config_header_splitter_top.sv]
// ----------------------------------------------------------------------------
// annexb_config_header_splitter_top
// Locates the SPS/VPS config header span in an Annex B frame, one byte per item.
// ----------------------------------------------------------------------------
// Result path: the frame summary register captures a frame's summary when its last
//   byte is accepted; the output register then loads the frame's result item.
// Throughput: one byte item per cycle, back to back across frames, unless a summary
//   waits on a stalled output; the summary and output registers hold one item each.
// Reset: rst_ni clears parser state, codec register (H.264) and the AV1 notice.
module annexb_config_header_splitter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: codec select (0 H.264, 1 HEVC, 2 AV1)
  input  logic                          cfg_wr_en_i,
  input  logic [1:0]                    cfg_wr_data_i,
  // input byte stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [acs_pkg::S_TDATA_W-1:0] s_axis_tdata_i,  // [7:0] data_byte
  input  logic                          s_axis_tlast_i,  // frame_end
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] frame_ignored, [1] config_found, [4:2] config_offset,
  // [28:5] config_length, [52:29] payload_offset, [76:53] payload_length,
  // [77] av1_config_notice, [78] too_long, [79] zero
  output logic [acs_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import acs_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [1:0] codec_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_cfg_q <= CODEC_H264;
    end else if (cfg_wr_en_i) begin
      codec_cfg_q <= cfg_wr_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Byte stage: per-frame parser state
  // --------------------------------------------------------------------------
  logic [23:0]      recent_q,  recent_d;
  logic [POS_W-1:0] pos_q,     pos_d;
  phase_e           phase_q,   phase_d;
  logic [2:0]       lead_q,    lead_d;
  logic [2:0]       skip_q,    skip_d;
  logic [1:0]       seen_q,    seen_d;
  logic             pend_q,    pend_d;
  logic [LEN_W-1:0] hdr_q,     hdr_d;
  logic             ovf_q,     ovf_d;
  logic [1:0]       codec_q,   codec_d;
  logic [1:0]       fill_q,    fill_d;

  logic             s_accept;
  logic             first_byte;
  phase_e           phase_eff;
  logic             is_h264;
  logic [7:0]       b;
  logic [5:0]       nal_t;
  logic [5:0]       aud_type;
  logic [5:0]       ps_type;
  logic [31:0]      win;
  logic [2:0]       fill_n;
  logic             last_code;
  logic [LEN_W-1:0] hdr_cand;
  pfx_e             pfx_lead;
  pfx_e             pfx_aud;

  // Start code whose first byte sits at index p; the current byte is at i.
  function automatic pfx_e prefix_check(input logic [POS_W-1:0] i,
                                        input logic [3:0]       p,
                                        input logic [15:0]      rec,
                                        input logic [7:0]       byte_v);
    logic [3:0] p2;
    logic [3:0] p3;
    pfx_e       r;
    p2 = p + 4'd2;
    p3 = p + 4'd3;
    r  = PFX_WAIT;
    if (i == POS_W'(p2)) begin
      if (rec != 16'h0000)      r = PFX_BAD;
      else if (byte_v == 8'h01) r = PFX_FOUND;
      else if (byte_v == 8'h00) r = PFX_WAIT;
      else                      r = PFX_BAD;
    end else if (i == POS_W'(p3)) begin
      r = (byte_v == 8'h01) ? PFX_FOUND : PFX_BAD;
    end
    return r;
  endfunction

  assign b          = s_axis_tdata_i[7:0];
  assign first_byte = (pos_q == '0) && !ovf_q;
  // Latch the codec on the first byte of the frame.
  assign codec_d    = first_byte ? codec_cfg_q : codec_q;
  assign phase_eff  = (first_byte && (codec_cfg_q != CODEC_H264) &&
                       (codec_cfg_q != CODEC_HEVC)) ? PH_IDLE : phase_q;
  assign is_h264    = (codec_d == CODEC_H264);
  assign nal_t      = is_h264 ? {1'b0, b[4:0]} : b[6:1];
  assign aud_type   = is_h264 ? NAL_AUD_H264 : NAL_AUD_HEVC;
  assign ps_type    = is_h264 ? NAL_SPS_H264 : NAL_VPS_HEVC;
  assign win        = {recent_q, b};
  assign fill_n     = ({1'b0, fill_q} + 3'd1 > 3'd4) ? 3'd4 : {1'b0, fill_q} + 3'd1;
  assign last_code  = ({1'b0, seen_q} + 3'd1) >= (is_h264 ? CODES_H264 : CODES_HEVC);
  // Start of a code found now sits three bytes back; measure from the skip.
  assign hdr_cand   = LEN_W'(pos_q) - LEN_W'({1'b0, skip_q} + 4'd3);
  assign pfx_lead   = prefix_check(pos_q, 4'd0, recent_q[15:0], b);
  assign pfx_aud    = prefix_check(pos_q, {1'b0, skip_q}, recent_q[15:0], b);

  always_comb begin
    phase_d  = phase_eff;
    lead_d   = lead_q;
    skip_d   = skip_q;
    seen_d   = seen_q;
    pend_d   = pend_q;
    hdr_d    = hdr_q;
    fill_d   = fill_q;
    recent_d = {recent_q[15:0], b};
    pos_d    = pos_q;
    ovf_d    = ovf_q;

    // Saturate the byte counter and flag the overflow.
    if (pos_q == POS_MAX) begin
      ovf_d = 1'b1;
    end else begin
      pos_d = pos_q + 1'b1;
    end

    unique case (phase_eff)
      PH_LEAD: begin
        if (pfx_lead == PFX_FOUND) begin
          lead_d  = 3'(pos_q + 1'b1);
          phase_d = PH_LEAD_TYPE;
        end else if (pfx_lead == PFX_BAD) begin
          phase_d = PH_IDLE;
        end
      end
      PH_LEAD_TYPE: begin
        if (nal_t == aud_type) begin
          skip_d  = lead_q + (is_h264 ? AUD_BODY_H264 : AUD_BODY_HEVC);
          phase_d = PH_AUD_PREFIX;
        end else if (nal_t == ps_type) begin
          phase_d = PH_SCAN;
          seen_d  = 2'd1;
          fill_d  = 2'd1;
          pend_d  = 1'b0;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_AUD_PREFIX: begin
        if (pfx_aud == PFX_FOUND) begin
          phase_d = PH_AUD_TYPE;
        end else if (pfx_aud == PFX_BAD) begin
          phase_d = PH_IDLE;
        end
      end
      PH_AUD_TYPE: begin
        if (nal_t == ps_type) begin
          phase_d = PH_SCAN;
          seen_d  = 2'd1;
          fill_d  = 2'd1;
          pend_d  = 1'b0;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_SCAN: begin
        if (pend_q || (fill_n == 3'd4 && win == 32'h0000_0001)) begin
          // Count a start code: a short one once a byte followed it, or a long one.
          pend_d = 1'b0;
          if (last_code) begin
            hdr_d   = hdr_cand;
            phase_d = PH_DONE;
          end else begin
            seen_d = seen_q + 2'd1;
            fill_d = pend_q ? 2'd1 : 2'd0;
          end
        end else if (fill_n >= 3'd3 && win[23:0] == 24'h00_0001) begin
          // Hold a short code until one more byte of the frame shows up.
          pend_d = 1'b1;
          fill_d = 2'd0;
        end else begin
          fill_d = (fill_n > 3'd3) ? 2'd3 : fill_n[1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake and pipeline control
  // --------------------------------------------------------------------------
  frame_sum_t        sum_q;
  logic              sum_valid_q;
  logic              out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;
  logic [M_TDATA_W-1:0] out_data_d;
  logic              out_load;
  logic              out_av1;
  logic              av1_sent_q;

  assign out_load        = sum_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !sum_valid_q || out_load;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      pos_q    <= '0;
      phase_q  <= PH_LEAD;
      lead_q   <= '0;
      skip_q   <= '0;
      seen_q   <= '0;
      pend_q   <= 1'b0;
      hdr_q    <= '0;
      ovf_q    <= 1'b0;
      codec_q  <= CODEC_H264;
      fill_q   <= '0;
    end else if (s_accept) begin
      if (s_axis_tlast_i) begin
        // Clear the parser for the next frame.
        recent_q <= '0;
        pos_q    <= '0;
        phase_q  <= PH_LEAD;
        lead_q   <= '0;
        skip_q   <= '0;
        seen_q   <= '0;
        pend_q   <= 1'b0;
        hdr_q    <= '0;
        ovf_q    <= 1'b0;
        codec_q  <= CODEC_H264;
        fill_q   <= '0;
      end else begin
        recent_q <= recent_d;
        pos_q    <= pos_d;
        phase_q  <= phase_d;
        lead_q   <= lead_d;
        skip_q   <= skip_d;
        seen_q   <= seen_d;
        pend_q   <= pend_d;
        hdr_q    <= hdr_d;
        ovf_q    <= ovf_d;
        codec_q  <= codec_d;
        fill_q   <= fill_d;
      end
    end
  end

  // Frame summary register: captured on the last byte of a frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (s_accept && s_axis_tlast_i) begin
      sum_valid_q <= 1'b1;
    end else if (out_load) begin
      sum_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept && s_axis_tlast_i) begin
      sum_q.len     <= pos_d;
      sum_q.ovf     <= ovf_d;
      sum_q.skip    <= skip_d;
      sum_q.lead    <= lead_d;
      sum_q.hdr_end <= hdr_d;
      sum_q.done    <= (phase_d == PH_DONE);
      sum_q.codec   <= codec_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result stage: spans and flags from the frame summary
  // --------------------------------------------------------------------------
  logic             r_short;
  logic             r_other;
  logic             r_skipped;
  logic             r_found;
  logic [2:0]       r_off;
  logic [LEN_W-1:0] r_cfg_len;
  logic [LEN_W-1:0] r_pay_off;
  logic [LEN_W-1:0] r_pay_len;

  assign r_short   = sum_q.len < POS_W'(4);
  assign r_other   = (sum_q.codec != CODEC_H264) && (sum_q.codec != CODEC_HEVC);
  assign r_skipped = (sum_q.skip != 3'd0) &&
                     (sum_q.len > POS_W'({1'b0, sum_q.skip} + {1'b0, sum_q.lead}));
  assign r_off     = r_skipped ? sum_q.skip : 3'd0;
  assign r_found   = sum_q.done && ((sum_q.skip == 3'd0) || r_skipped);
  assign r_cfg_len = r_found ? sum_q.hdr_end : '0;
  assign r_pay_off = LEN_W'(r_off) + r_cfg_len;

  always_comb begin
    out_av1    = 1'b0;
    r_pay_len  = LEN_W'(sum_q.len) - r_pay_off;
    out_data_d = {1'b0, sum_q.ovf, 1'b0, r_pay_len, r_pay_off, r_cfg_len, r_off,
                  r_found, 1'b0};
    if (r_short) begin
      // Drop short frames: only the ignore flag is set.
      out_data_d = {{(M_TDATA_W-1){1'b0}}, 1'b1};
    end else if (r_other) begin
      // AV1 and unknown codecs: whole frame is payload.
      out_av1    = (sum_q.codec == CODEC_AV1) && !av1_sent_q;
      out_data_d = {1'b0, sum_q.ovf, out_av1, LEN_W'(sum_q.len),
                    {(2*LEN_W+5){1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      av1_sent_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load && out_av1) begin
        av1_sent_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_sum_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid_o)
    else $error("summary consumed without a result item");

  a_av1_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_av1) |=> (av1_sent_q && !out_av1))
    else $error("AV1 notice not recorded");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tlast_i) |=> (pos_q == '0 && phase_q == PH_LEAD && !ovf_q))
    else $error("parser state not cleared after frame end");

  a_pay_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[1] && !m_axis_tdata_o[78])
      |-> (m_axis_tdata_o[52:29] >= m_axis_tdata_o[28:5]))
    else $error("payload starts inside the config span");

endmodule

[bench/split_result_checker.sv]
// ----------------------------------------------------------------------------
// split_result_checker
// Watches the byte and result streams of the config header splitter, predicts
// the split of every frame from the accepted bytes and compares each result.
// ----------------------------------------------------------------------------
module split_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [1:0]                    cfg_wr_data_i,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [acs_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic [acs_pkg::M_TDATA_W-1:0] m_axis_tdata_i,
  output int                            mismatch_count_o,
  output int                            splits_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import acs_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX       = '1;
  localparam int unsigned      MIN_FRAME_LEN = 4;

  // Result item, lowest field last.
  typedef struct packed {
    logic             pad;
    logic             too_long;
    logic             av1_notice;
    logic [LEN_W-1:0] pay_len;
    logic [LEN_W-1:0] pay_off;
    logic [LEN_W-1:0] cfg_len;
    logic [2:0]       cfg_off;
    logic             found;
    logic             ignored;
  } split_result_t;

  split_result_t expected_splits[$];

  logic [1:0]       codec_reg;
  logic [1:0]       frame_codec;
  logic [23:0]      recent;
  logic [POS_W-1:0] pos;
  phase_e           phase;
  logic [2:0]       lead_size;
  logic [2:0]       skip_amt;
  int unsigned      codes_seen;
  logic             code_pending;
  logic [LEN_W-1:0] hdr_end;
  logic             overflow;
  logic             av1_sent;
  int unsigned      win_fill;

  initial mismatch_count_o = 0;
  initial splits_pending_o = 0;

  function automatic void clear_frame();
    recent       = '0;
    pos          = '0;
    phase        = PH_LEAD;
    lead_size    = '0;
    skip_amt     = '0;
    codes_seen   = 0;
    code_pending = 1'b0;
    hdr_end      = '0;
    overflow     = 1'b0;
    frame_codec  = CODEC_H264;
    win_fill     = 0;
  endfunction

  // Start code whose first byte sits at p; the current byte sits at i.
  function automatic pfx_e check_prefix(input longint unsigned i,
                                        input longint unsigned p,
                                        input logic [7:0] b);
    if (i == p + 2) begin
      if (recent[15:0] != 16'h0000) return PFX_BAD;
      if (b == 8'h01) return PFX_FOUND;
      return (b == 8'h00) ? PFX_WAIT : PFX_BAD;
    end
    if (i == p + 3) return (b == 8'h01) ? PFX_FOUND : PFX_BAD;
    return PFX_WAIT;
  endfunction

  function automatic logic [5:0] nal_kind(input logic [7:0] b);
    return (frame_codec == CODEC_H264) ? {1'b0, b[4:0]} : b[6:1];
  endfunction

  function automatic void enter_scan();
    phase        = PH_SCAN;
    codes_seen   = 1;
    win_fill     = 1;
    code_pending = 1'b0;
  endfunction

  function automatic void count_code(input longint unsigned at,
                                     input int unsigned next_fill);
    int unsigned target;
    target = (frame_codec == CODEC_H264) ? CODES_H264 : CODES_HEVC;
    if (codes_seen + 1 >= target) begin
      hdr_end = LEN_W'(at - skip_amt);
      phase   = PH_DONE;
    end else begin
      codes_seen = codes_seen + 1;
      win_fill   = next_fill;
    end
  endfunction

  function automatic void scan_byte(input longint unsigned i, input logic [7:0] b);
    logic [31:0] w;
    int unsigned n;
    w = {recent, b};
    n = win_fill + 1;
    // A short code is only counted once the byte after it shows up.
    if (code_pending) begin
      code_pending = 1'b0;
      count_code(i - 3, 1);
      return;
    end
    if (n > 4) n = 4;
    if (n >= 4 && w == 32'h0000_0001) begin
      count_code(i - 3, 0);
    end else if (n >= 3 && w[23:0] == 24'h00_0001) begin
      code_pending = 1'b1;
      win_fill     = 0;
    end else begin
      win_fill = (n > 3) ? 3 : n;
    end
  endfunction

  function automatic void parse_byte(input longint unsigned i, input logic [7:0] b);
    pfx_e       r;
    logic [5:0] t;
    logic       is_h264;
    is_h264 = (frame_codec == CODEC_H264);
    case (phase)
      PH_LEAD: begin
        r = check_prefix(i, 0, b);
        if (r == PFX_FOUND) begin
          lead_size = 3'(i + 1);
          phase     = PH_LEAD_TYPE;
        end else if (r == PFX_BAD) begin
          phase = PH_IDLE;
        end
      end
      PH_LEAD_TYPE: begin
        t = nal_kind(b);
        if (t == (is_h264 ? NAL_AUD_H264 : NAL_AUD_HEVC)) begin
          skip_amt = lead_size + (is_h264 ? AUD_BODY_H264 : AUD_BODY_HEVC);
          phase    = PH_AUD_PREFIX;
        end else if (t == (is_h264 ? NAL_SPS_H264 : NAL_VPS_HEVC)) begin
          enter_scan();
        end else begin
          phase = PH_IDLE;
        end
      end
      PH_AUD_PREFIX: begin
        r = check_prefix(i, skip_amt, b);
        if (r == PFX_FOUND) phase = PH_AUD_TYPE;
        else if (r == PFX_BAD) phase = PH_IDLE;
      end
      PH_AUD_TYPE: begin
        if (nal_kind(b) == (is_h264 ? NAL_SPS_H264 : NAL_VPS_HEVC)) enter_scan();
        else phase = PH_IDLE;
      end
      PH_SCAN: scan_byte(i, b);
      default: ;
    endcase
  endfunction

  // Advance the frame parser by one byte; on the last byte queue the split.
  function automatic void predict_split(input logic [7:0] b, input logic last);
    longint unsigned i, len, off, poff, lim;
    logic            skipped, found;
    split_result_t   r;
    i = pos;
    if (pos == '0 && !overflow) begin
      frame_codec = codec_reg;
      if (frame_codec > CODEC_HEVC) phase = PH_IDLE;
    end
    parse_byte(i, b);
    recent = {recent[15:0], b};
    if (pos == POS_MAX) overflow = 1'b1;
    else pos = pos + 1'b1;
    if (!last) return;

    r          = '0;
    len        = pos;
    r.too_long = overflow;
    if (len < MIN_FRAME_LEN) begin
      r.ignored  = 1'b1;
      r.too_long = 1'b0;
    end else if (frame_codec > CODEC_HEVC) begin
      // Whole frame is payload; only the first AV1 frame that is not short announces.
      if (frame_codec == CODEC_AV1 && !av1_sent) begin
        av1_sent     = 1'b1;
        r.av1_notice = 1'b1;
      end
      r.pay_len = LEN_W'(len);
    end else begin
      lim       = skip_amt + lead_size;
      skipped   = (skip_amt != 0) && (len > lim);
      off       = skipped ? skip_amt : 0;
      found     = (phase == PH_DONE) && (skip_amt == 0 || skipped);
      poff      = off + (found ? hdr_end : 0);
      r.found   = found;
      r.cfg_off = 3'(off);
      r.cfg_len = found ? hdr_end : '0;
      r.pay_off = LEN_W'(poff);
      r.pay_len = LEN_W'(len - poff);
    end
    expected_splits.push_back(r);
    clear_frame();
  endfunction

  task automatic report_split_error(input string what, input split_result_t got,
                                    input split_result_t want);
    mismatch_count_o = mismatch_count_o + 1;
    $display({"%t ERROR %s: got ign=%0d cfg=%0d coff=%0d clen=%0d poff=%0d plen=%0d",
              " av1=%0d long=%0d ; want ign=%0d cfg=%0d coff=%0d clen=%0d poff=%0d",
              " plen=%0d av1=%0d long=%0d"},
             $realtime, what,
             got.ignored, got.found, got.cfg_off, got.cfg_len, got.pay_off, got.pay_len,
             got.av1_notice, got.too_long,
             want.ignored, want.found, want.cfg_off, want.cfg_len, want.pay_off,
             want.pay_len, want.av1_notice, want.too_long);
  endtask

  task automatic check_split(input split_result_t got);
    split_result_t want;
    if (expected_splits.size() == 0) begin
      report_split_error("result with no frame pending", got, '0);
      return;
    end
    want = expected_splits.pop_front();
    if (got.ignored    != want.ignored    || got.found    != want.found    ||
        got.cfg_off    != want.cfg_off    || got.cfg_len  != want.cfg_len  ||
        got.pay_off    != want.pay_off    || got.pay_len  != want.pay_len  ||
        got.av1_notice != want.av1_notice || got.too_long != want.too_long) begin
      report_split_error("split differs", got, want);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_reg = CODEC_H264;
      av1_sent  = 1'b0;
      clear_frame();
      expected_splits.delete();
    end else begin
      // A byte taken at this edge still sees the codec from before the edge.
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_split(s_axis_tdata_i, s_axis_tlast_i);
      end
      if (cfg_wr_en_i) codec_reg = cfg_wr_data_i;
      if (m_axis_tvalid_i && m_axis_tready_i) check_split(split_result_t'(m_axis_tdata_i));
    end
    splits_pending_o = expected_splits.size();
  end

endmodule

[bench/tb_annexb_config_header_splitter_top.sv]
// ----------------------------------------------------------------------------
// tb_annexb_config_header_splitter_top
// Drives Annex B frames into the config header splitter under all codec
// settings and four idling mixes; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_annexb_config_header_splitter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import acs_pkg::*;

  localparam time         CLK_PERIOD     = 10ns;
  localparam int          RESET_CYCLES   = 3;
  localparam int          RANDOM_BYTES   = 1340;
  localparam int          DRAIN_CYCLES   = 4;     // result passes the summary and output registers
  localparam int          WATCHDOG_LIMIT = 2000;  // far above the longest 88% stall run
  localparam logic [1:0]  CODEC_RSVD     = 2'd3;  // unused code, treated as pass-through

  // Extra NAL types used to fill out realistic frames.
  localparam logic [5:0] NAL_PPS_H264 = 6'd8;
  localparam logic [5:0] NAL_IDR_H264 = 6'd5;
  localparam logic [5:0] NAL_SPS_HEVC = 6'd33;
  localparam logic [5:0] NAL_PPS_HEVC = 6'd34;
  localparam logic [5:0] NAL_IDR_HEVC = 6'd19;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_wr_en_i     = 1'b0;
  logic [1:0]           cfg_wr_data_i   = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic                 s_axis_tlast_i  = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;

  int          mismatch_count;
  int          splits_pending;
  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  int          bytes_sent     = 0;
  int          idle_run       = 0;
  logic [1:0]  cur_codec      = CODEC_H264;
  logic [7:0]  frame_q[$];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  annexb_config_header_splitter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  split_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_wr_en_i      (cfg_wr_en_i),
    .cfg_wr_data_i    (cfg_wr_data_i),
    .s_axis_tvalid_i  (s_axis_tvalid_i),
    .s_axis_tready_i  (s_axis_tready_o),
    .s_axis_tdata_i   (s_axis_tdata_i),
    .s_axis_tlast_i   (s_axis_tlast_i),
    .m_axis_tvalid_i  (m_axis_tvalid_o),
    .m_axis_tready_i  (m_axis_tready_i),
    .m_axis_tdata_i   (m_axis_tdata_o),
    .mismatch_count_o (mismatch_count),
    .splits_pending_o (splits_pending)
  );

  // Throttle the result side: one roll per cycle, changed on the falling edge
  // so the sampled value is stable at the rising edge.
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: any cycle without a handshake on either stream counts toward
  // the limit; a hang or a result that never shows up ends here.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Offer one byte item, with a random sender gap first, and hold it until
  // the block takes it. Entered just after a rising edge.
  task automatic drive_byte(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Push the staged frame out, tlast on its final byte, then drop it.
  task automatic send_frame();
    for (int k = 0; k < frame_q.size(); k++) begin
      drive_byte(frame_q[k], k == frame_q.size() - 1);
    end
    frame_q.delete();
  endtask

  // Drop valid and wait until every predicted split has been seen, plus the
  // pipeline depth, so the block is idle.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (splits_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_codec(input logic [1:0] codec);
    settle();
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= codec;
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    cur_codec = codec;
  endtask

  // Zero-heavy filler so start codes and near misses show up inside bodies.
  function automatic logic [7:0] body_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 25) return 8'h00;
    if (roll < 33) return 8'h01;
    return 8'($urandom_range(255));
  endfunction

  task automatic put_start(input bit long_code);
    if (long_code) frame_q.push_back(8'h00);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h01);
  endtask

  // Start code, NAL header (one byte for H.264, two for HEVC), then a body.
  // Bits the type decode ignores are randomized.
  task automatic put_nal(input logic hevc, input logic [5:0] kind, input int body_len);
    put_start(1'($urandom_range(1)));
    if (hevc) begin
      frame_q.push_back({1'($urandom_range(1)), kind, 1'($urandom_range(1))});
      frame_q.push_back(8'($urandom_range(1, 7)));
    end else begin
      frame_q.push_back({1'($urandom_range(1)), 2'($urandom_range(3)), kind[4:0]});
    end
    repeat (body_len) frame_q.push_back(body_byte());
  endtask

  // Delimiter (optional), parameter sets, maybe some extras, then a slice.
  task automatic build_wellformed(input logic hevc);
    logic [5:0] first_kind;
    if ($urandom_range(1)) put_nal(hevc, hevc ? NAL_AUD_HEVC : NAL_AUD_H264, 1);
    if ($urandom_range(99) < 85) first_kind = hevc ? NAL_VPS_HEVC : NAL_SPS_H264;
    else first_kind = hevc ? 6'($urandom_range(63)) : 6'($urandom_range(31));
    put_nal(hevc, first_kind, $urandom_range(0, 4));
    if (hevc) put_nal(hevc, NAL_SPS_HEVC, $urandom_range(0, 4));
    put_nal(hevc, hevc ? NAL_PPS_HEVC : NAL_PPS_H264, $urandom_range(0, 4));
    repeat ($urandom_range(0, 2)) put_nal(hevc, 6'($urandom_range(63)), $urandom_range(0, 3));
    put_nal(hevc, hevc ? NAL_IDR_HEVC : NAL_IDR_H264, $urandom_range(1, 8));
  endtask

  // Mostly well-formed frames; the rest truncated, corrupted or plain noise.
  task automatic build_random_frame(input logic [1:0] codec);
    int unsigned roll;
    int          keep;
    logic        hevc;
    roll = $urandom_range(99);
    hevc = (codec == CODEC_H264) ? 1'b0 :
           (codec == CODEC_HEVC) ? 1'b1 : 1'($urandom_range(1));
    if (roll < 70) begin
      build_wellformed(hevc);
    end else if (roll < 85) begin
      build_wellformed(hevc);
      if ($urandom_range(1)) begin
        keep = $urandom_range(1, frame_q.size());
        while (frame_q.size() > keep) void'(frame_q.pop_back());
      end else begin
        frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom_range(255));
      end
    end else begin
      repeat ($urandom_range(1, 14)) frame_q.push_back(body_byte());
    end
  endtask

  function automatic logic [1:0] pick_codec();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return CODEC_H264;
    if (roll < 80) return CODEC_HEVC;
    if (roll < 94) return CODEC_AV1;
    return CODEC_RSVD;
  endfunction

  initial begin
    int ph;
    int budget;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---------------- directed frames, no idling ----------------
    write_codec(CODEC_H264);
    // Short frames: one byte at the top of the byte range, then a bare code.
    frame_q = {8'hFF};
    send_frame();
    frame_q = {8'h00, 8'h00, 8'h01};
    send_frame();
    // SPS, PPS, slice with short codes: the third code closes the span.
    frame_q = {8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01, 8'h68,
               8'h00, 8'h00, 8'h01, 8'h65, 8'hAA};
    send_frame();
    // Leading delimiter skipped, long codes throughout.
    frame_q = {8'h00, 8'h00, 8'h00, 8'h01, 8'h09, 8'hF0,
               8'h00, 8'h00, 8'h00, 8'h01, 8'h27, 8'h00, 8'h00, 8'h00, 8'h01, 8'h28,
               8'h00, 8'h00, 8'h00, 8'h01, 8'h25, 8'hFF};
    send_frame();
    // No start code at the head.
    frame_q = {8'h12, 8'h34, 8'h56, 8'h78};
    send_frame();
    // Frame ends before the NAL type byte.
    frame_q = {8'h00, 8'h00, 8'h00, 8'h01};
    send_frame();
    // Delimiter present but frame too short for the skip to apply.
    frame_q = {8'h00, 8'h00, 8'h01, 8'h09, 8'hF0};
    send_frame();
    // Third short code is the last thing in the frame, so it never counts.
    frame_q = {8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01, 8'h68,
               8'h00, 8'h00, 8'h01};
    send_frame();

    write_codec(CODEC_HEVC);
    frame_q = {8'h00, 8'h00, 8'h00, 8'h01, 8'h46, 8'h01, 8'h50,
               8'h00, 8'h00, 8'h01, 8'h40, 8'h01, 8'h00, 8'h00, 8'h01, 8'h42, 8'h01,
               8'h00, 8'h00, 8'h01, 8'h44, 8'h01, 8'h00, 8'h00, 8'h01, 8'h26, 8'h01, 8'h80};
    send_frame();

    // A short AV1 frame must not use up the one-time notice.
    write_codec(CODEC_AV1);
    frame_q = {8'h0A, 8'h0B};
    send_frame();
    frame_q = {8'h12, 8'h00, 8'h0A, 8'h0B, 8'h00};
    send_frame();
    frame_q = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame();

    write_codec(CODEC_RSVD);
    frame_q = {8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00};
    send_frame();

    // ---------------- random frames over four idling mixes ----------------
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 88; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 88; end
        default: begin src_idle_pct = 13; sink_stall_pct = 13; end
      endcase
      budget = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < budget) begin
        // Switch codec now and then; write_codec waits for the block to idle.
        if ($urandom_range(3) == 0) write_codec(pick_codec());
        build_random_frame(cur_codec);
        send_frame();
      end
    end

    // Wait out every outstanding result, then give the verdict.
    settle();
    if (mismatch_count == 0 && splits_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
